FILE: src/morph_weight_keyframe_interpolator_assert.svh
// Assertion macros shared by the keyframe interpolator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MORPH_WEIGHT_KEYFRAME_INTERPOLATOR_ASSERT_SVH
`define MORPH_WEIGHT_KEYFRAME_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWKI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe interpolator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MWKI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe interpolator: assertion failed");

`endif

FILE: src/mwki_pkg.sv
// Package of the keyframe interpolator: codes, types and default sizes.
// Depends on nothing; used by every RTL file of the block.
`default_nettype none

package mwki_pkg;

    localparam int TRACKS_DEF = 16;
    localparam int KEYS_DEF   = 64;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_WEIGHT = 2'd0;
    localparam logic [1:0] ST_OK     = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_EPRE,
        S_ETRK,
        S_ELAST,
        S_EFIRST,
        S_ESEG,
        S_EDIV,
        S_PUSH
    } t_state;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_SUM,
        DV_RUN,
        DV_FIN
    } t_div_state;

    typedef struct packed {
        logic key_wr;
        logic key_rd;
        logic cnt_wr;
    } t_store_ctl;

endpackage

`default_nettype wire

FILE: src/mwki_store.sv
// Keyframe memory (frame and weight per entry) and per-track fill counts.
// Depends on mwki_pkg for the control struct.
`default_nettype none

module mwki_store import mwki_pkg::*; #(
    parameter int TRACKS = TRACKS_DEF,
    parameter int KEYS   = KEYS_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  t_store_ctl                                i_ctl,
    input  wire [((TRACKS > 1) ? $clog2(TRACKS) : 1) + $clog2(KEYS)-1:0] i_key_addr,
    input  wire [31:0]                                i_key_wdata,
    output logic [31:0]                               o_key_rdata,
    input  wire [((TRACKS > 1) ? $clog2(TRACKS) : 1)-1:0] i_cnt_sel,
    input  wire [$clog2(KEYS + 1)-1:0]                i_cnt_wdata,
    output logic [$clog2(KEYS + 1)-1:0]               o_cnt_rdata
);

    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int KW = $clog2(KEYS);
    localparam int AW = TW + KW;
    localparam int CW = $clog2(KEYS + 1);

    logic [31:0]   r_mem [2**AW];
    logic [CW-1:0] r_cnt [2**TW];

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_wr) begin
            r_mem[i_key_addr] <= i_key_wdata;
        end
        if (i_ctl.key_rd) begin
            o_key_rdata <= r_mem[i_key_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2**TW; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_ctl.cnt_wr) begin
            r_cnt[i_cnt_sel] <= i_cnt_wdata;
        end
    end

    assign o_cnt_rdata = r_cnt[i_cnt_sel];

endmodule

`default_nettype wire

FILE: src/mwki_div.sv
// Interpolation unit: one multiply, then a bit-serial restoring divide with rounding.
// Depends on mwki_pkg for the sequencer states.
`default_nettype none

module mwki_div import mwki_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [15:0] i_wa,
    input  wire signed [15:0] i_wb,
    input  wire [23:0]        i_num,
    input  wire [23:0]        i_den,
    output logic              o_done,
    output logic signed [15:0] o_result
);

    // The numerator carries a bias of 2^17 divisors so that it is never negative;
    // the quotient then floors correctly and the bias is taken off at the end.
    t_div_state          r_st, n_st;
    logic signed [16:0]  r_d;
    logic signed [15:0]  r_wa;
    logic [23:0]         r_num, r_den;
    logic signed [41:0]  r_prod;
    logic [42:0]         r_dvd;
    logic [25:0]         r_rem;
    logic [18:0]         r_quo;
    logic [5:0]          r_cnt;
    logic [25:0]         rem_sh, divisor;
    logic                ge;
    logic signed [19:0]  sum;

    assign divisor = {1'b0, r_den, 1'b0};
    assign rem_sh  = {r_rem[24:0], r_dvd[42]};
    assign ge      = rem_sh >= divisor;
    assign sum     = $signed({{4{r_wa[15]}}, r_wa}) + $signed({1'b0, r_quo})
                     - 20'sd131072;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= DV_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            DV_IDLE: if (i_start) n_st = DV_MUL;
            DV_MUL:  n_st = DV_SUM;
            DV_SUM:  n_st = DV_RUN;
            DV_RUN:  if (r_cnt == 6'd1) n_st = DV_FIN;
            DV_FIN:  n_st = DV_IDLE;
            default: n_st = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (r_st == DV_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            DV_IDLE: begin
                r_d   <= $signed({i_wb[15], i_wb}) - $signed({i_wa[15], i_wa});
                r_wa  <= i_wa;
                r_num <= i_num;
                r_den <= i_den;
            end
            DV_MUL: begin
                r_prod <= r_d * $signed({1'b0, r_num});
            end
            DV_SUM: begin
                r_dvd <= 43'(({{2{r_prod[41]}}, r_prod} <<< 1) + {20'd0, r_den}
                             + {2'd0, r_den, 18'd0});
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 6'd43;
            end
            DV_RUN: begin
                r_rem <= ge ? (rem_sh - divisor) : rem_sh;
                r_quo <= {r_quo[17:0], ge};
                r_dvd <= {r_dvd[41:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            DV_FIN: begin
                o_result <= sum[15:0];
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/morph_weight_keyframe_interpolator.sv
// Top level of the morph weight keyframe interpolator: control sequencer and output register.
// Depends on mwki_pkg, mwki_store, mwki_div and the assertion macro header.
//
//   Channel  Handshake                Payload
//   input    i_in_valid / o_in_ready  i_opcode, i_track, i_key_frame, i_key_weight,
//                                     i_query_frame
//   output   o_out_valid / i_out_ready o_out_track, o_weight, o_status, o_last
//
// An append or a clear gives one result. An evaluation first sweeps the fill counts,
// then for each non-empty track reads the last and first keyframes and walks its keys
// one per cycle through the single memory read port; a segment hit then waits on the
// serial divider.
// Reset is synchronous and active low; it clears the fill counts and the control state,
// while the keyframe memory holds whatever was last written.
// One request is in work at a time; a stalled output holds the sequencer at its result.
`default_nettype none

module morph_weight_keyframe_interpolator import mwki_pkg::*; #(
    parameter int TRACKS = TRACKS_DEF,
    parameter int KEYS   = KEYS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire [1:0]         i_opcode,
    input  wire [3:0]         i_track,
    input  wire [15:0]        i_key_frame,
    input  wire signed [15:0] i_key_weight,
    input  wire [23:0]        i_query_frame,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [3:0]        o_out_track,
    output logic signed [15:0] o_weight,
    output logic [1:0]        o_status,
    output logic              o_last
);

`include "morph_weight_keyframe_interpolator_assert.svh"

    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int KW = $clog2(KEYS);
    localparam int CW = $clog2(KEYS + 1);

    // Sequencer state and the request being worked on.
    t_state              r_state, n_state;
    logic [3:0]          r_trk, n_trk;
    logic [23:0]         r_q, n_q;
    logic [1:0]          r_rstat, n_rstat;
    logic [TW-1:0]       r_ti, n_ti;
    logic [TW-1:0]       r_lastt, n_lastt;
    logic                r_any, n_any;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [KW-1:0]       r_kidx, n_kidx;
    logic [15:0]         r_lf, n_lf, r_pf, n_pf;
    logic signed [15:0]  r_lw, n_lw, r_pw, n_pw, r_res, n_res;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [3:0]          r_out_track, n_out_track;
    logic signed [15:0]  r_out_weight, n_out_weight;
    logic [1:0]          r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    // Memory and divider connections.
    t_store_ctl          store_ctl;
    logic [TW+KW-1:0]    key_addr;
    logic [31:0]         key_wdata, key_rdata;
    logic [TW-1:0]       cnt_sel;
    logic [CW-1:0]       cnt_wdata, cnt_rdata;
    logic                div_start, div_done;
    logic signed [15:0]  div_result;
    logic [15:0]         rd_frame;
    logic signed [15:0]  rd_weight;
    logic                slot_free, trk_ok;

    assign rd_frame  = key_rdata[31:16];
    assign rd_weight = key_rdata[15:0];
    assign slot_free = !r_out_valid || i_out_ready;
    assign trk_ok    = {28'd0, i_track} < 32'(TRACKS);

    mwki_store #(
        .TRACKS (TRACKS),
        .KEYS   (KEYS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (store_ctl),
        .i_key_addr  (key_addr),
        .i_key_wdata (key_wdata),
        .o_key_rdata (key_rdata),
        .i_cnt_sel   (cnt_sel),
        .i_cnt_wdata (cnt_wdata),
        .o_cnt_rdata (cnt_rdata)
    );

    // The divider samples its operands on the start cycle: the memory word of the
    // upper keyframe together with the lower keyframe held in the sequencer.
    mwki_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_wa     (r_pw),
        .i_wb     (rd_weight),
        .i_num    (r_q - {r_pf, 8'd0}),
        .i_den    ({rd_frame, 8'd0} - {r_pf, 8'd0}),
        .o_done   (div_done),
        .o_result (div_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_trk        <= n_trk;
        r_q          <= n_q;
        r_rstat      <= n_rstat;
        r_ti         <= n_ti;
        r_lastt      <= n_lastt;
        r_any        <= n_any;
        r_cnt        <= n_cnt;
        r_kidx       <= n_kidx;
        r_lf         <= n_lf;
        r_lw         <= n_lw;
        r_pf         <= n_pf;
        r_pw         <= n_pw;
        r_res        <= n_res;
        r_out_track  <= n_out_track;
        r_out_weight <= n_out_weight;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_trk        = r_trk;
        n_q          = r_q;
        n_rstat      = r_rstat;
        n_ti         = r_ti;
        n_lastt      = r_lastt;
        n_any        = r_any;
        n_cnt        = r_cnt;
        n_kidx       = r_kidx;
        n_lf         = r_lf;
        n_lw         = r_lw;
        n_pf         = r_pf;
        n_pw         = r_pw;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_track  = r_out_track;
        n_out_weight = r_out_weight;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        store_ctl    = '0;
        key_addr     = {r_ti, r_kidx};
        key_wdata    = {i_key_frame, i_key_weight};
        cnt_sel      = r_ti;
        cnt_wdata    = '0;
        div_start    = 1'b0;
        o_in_ready   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                cnt_sel    = TW'(i_track);
                key_addr   = {TW'(i_track), KW'(cnt_rdata)};
                if (i_in_valid) begin
                    n_trk = i_track;
                    n_q   = i_query_frame;
                    unique case (t_opcode'(i_opcode))
                        OP_APPEND: begin
                            // A full track or one beyond the store drops the key.
                            if (!trk_ok || cnt_rdata >= CW'(KEYS)) begin
                                n_rstat = ST_FULL;
                            end else begin
                                store_ctl.key_wr = 1'b1;
                                store_ctl.cnt_wr = 1'b1;
                                cnt_wdata        = cnt_rdata + CW'(1);
                                n_rstat          = ST_OK;
                            end
                            n_state = S_RESP;
                        end
                        OP_CLEAR: begin
                            store_ctl.cnt_wr = trk_ok;
                            n_rstat          = ST_OK;
                            n_state          = S_RESP;
                        end
                        OP_EVAL: begin
                            n_ti    = '0;
                            n_any   = 1'b0;
                            n_lastt = '0;
                            n_state = S_EPRE;
                        end
                        OP_NOP: ;
                        default: ;
                    endcase
                end
            end

            S_RESP: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_track  = r_trk;
                    n_out_weight = '0;
                    n_out_status = r_rstat;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            // Sweep the counts to learn which non-empty track comes last, so that
            // the final weight result can carry the last flag, or that no track holds keys.
            S_EPRE: begin
                if (cnt_rdata != '0) begin
                    n_any   = 1'b1;
                    n_lastt = r_ti;
                end
                if (r_ti == TW'(TRACKS - 1)) begin
                    n_ti = '0;
                    if (!(r_any || cnt_rdata != '0)) begin
                        n_rstat = ST_NONE;
                        n_trk   = '0;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_ETRK;
                    end
                end else begin
                    n_ti = r_ti + TW'(1);
                end
            end

            S_ETRK: begin
                n_cnt = cnt_rdata;
                if (cnt_rdata == '0) begin
                    n_ti = r_ti + TW'(1);
                end else begin
                    key_addr         = {r_ti, KW'(cnt_rdata - CW'(1))};
                    store_ctl.key_rd = 1'b1;
                    n_state          = S_ELAST;
                end
            end

            S_ELAST: begin
                n_lf             = rd_frame;
                n_lw             = rd_weight;
                key_addr         = {r_ti, KW'(0)};
                store_ctl.key_rd = 1'b1;
                n_state          = S_EFIRST;
            end

            // Clamp at or before the first key or at and after the last key; otherwise
            // walk the segments from the start.
            S_EFIRST: begin
                if (r_q <= {rd_frame, 8'd0}) begin
                    n_res   = rd_weight;
                    n_state = S_PUSH;
                end else if (r_q >= {r_lf, 8'd0}) begin
                    n_res   = r_lw;
                    n_state = S_PUSH;
                end else begin
                    n_pf             = rd_frame;
                    n_pw             = rd_weight;
                    n_kidx           = KW'(1);
                    key_addr         = {r_ti, KW'(1)};
                    store_ctl.key_rd = 1'b1;
                    n_state          = S_ESEG;
                end
            end

            // A segment of zero length never holds the query and falls through.
            S_ESEG: begin
                if (r_q >= {r_pf, 8'd0} && r_q < {rd_frame, 8'd0}) begin
                    div_start = 1'b1;
                    n_state   = S_EDIV;
                end else if (r_kidx == KW'(r_cnt - CW'(1))) begin
                    n_res   = r_lw;
                    n_state = S_PUSH;
                end else begin
                    n_pf             = rd_frame;
                    n_pw             = rd_weight;
                    n_kidx           = r_kidx + KW'(1);
                    key_addr         = {r_ti, r_kidx + KW'(1)};
                    store_ctl.key_rd = 1'b1;
                end
            end

            S_EDIV: begin
                if (div_done) begin
                    n_res   = div_result;
                    n_state = S_PUSH;
                end
            end

            S_PUSH: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_track  = 4'(r_ti);
                    n_out_weight = r_res;
                    n_out_status = ST_WEIGHT;
                    n_out_last   = (r_ti == r_lastt);
                    if (r_ti == r_lastt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ti    = r_ti + TW'(1);
                        n_state = S_ETRK;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_track = r_out_track;
    assign o_weight    = r_out_weight;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    // A keyframe is only written into a track that still has room.
    `MWKI_ASSERT_IMPL(a_wr_room, i_clk, i_rst_n, store_ctl.key_wr, cnt_rdata < CW'(KEYS))
    // The empty-store result always closes its request.
    `MWKI_ASSERT_IMPL(a_none_last, i_clk, i_rst_n, r_out_valid && r_out_status == ST_NONE,
        r_out_last)
    // The segment walk never reads beyond the track's fill.
    `MWKI_ASSERT_IMPL(a_seg_idx, i_clk, i_rst_n, r_state == S_ESEG, CW'(r_kidx) < r_cnt)
    // The divider reports completion only while the sequencer waits for it.
    `MWKI_ASSERT_IMPL(a_div_wait, i_clk, i_rst_n, div_done, r_state == S_EDIV)

endmodule

`default_nettype wire
